// File: hdl/tes_pkg.sv
// shared types and constants for the target easing smoother
package tes_pkg;

	localparam int AXES_DEF        = 3;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_TICKS_DEF   = 255;

	localparam int FIELD_W     = 32;
	localparam int CMD_W       = 2;
	localparam int INDEX_W     = 3;
	localparam int TICK_W      = 8;
	localparam int RATE_W      = 16;
	localparam int THR_W       = 31;
	localparam int CFG_W       = 31;
	localparam int REG_IDX_W   = 2;
	localparam int OUT_FIELDS  = 6;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = OUT_FIELDS * FIELD_W;

	localparam logic [RATE_W-1:0] UNITY_RATE     = 16'd256;
	localparam logic [RATE_W-1:0] RATE_RESET     = 16'd256;
	localparam logic [THR_W-1:0]  SNAP_THR_RESET = 31'd6554;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_ADVANCE = 2'd1,
		CMD_JUMP    = 2'd2,
		CMD_HOLD    = 2'd3
	} cmd_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_POSITION_RATE  = 2'd0,
		REG_REFERENCE_RATE = 2'd1,
		REG_SNAP_THRESHOLD = 2'd2,
		REG_FROZEN         = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_DIV,
		ST_WAIT,
		ST_MOVE,
		ST_SNAP,
		ST_FINISH
	} state_t;

	// rates below one (Q8.8) act as one
	function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] r);
		return (r < UNITY_RATE) ? UNITY_RATE : r;
	endfunction

endpackage

// File: hdl/tes_div.sv
// restoring bit-serial divider: quotient of (mag * 256) / divisor, divisor >= 256
module tes_div import tes_pkg::*; #(
	parameter int QW = VALUE_WIDTH_DEF + 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [QW-1:0]     mag,
	input  logic [RATE_W-1:0] divisor,
	output logic              done,
	output logic [QW-1:0]     quo
);

	localparam int CNT_W = $clog2(QW);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RATE_W-1:0] rem_q;
	logic [RATE_W-1:0] dvs_q;
	logic [QW-1:0]     sh_q;
	logic [RATE_W:0]   trial;
	logic              fits;

	// top eight dividend bits are below the divisor, so their quotient bits are zero
	assign trial = {rem_q, sh_q[QW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RATE_W'(mag[QW-1 -: 8]);
			sh_q  <= {mag[QW-9:0], 8'd0};
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? RATE_W'(trial - {1'b0, dvs_q}) : trial[RATE_W-1:0];
			sh_q  <= {sh_q[QW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a running division");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

endmodule

// File: hdl/target_easing_smoother_top.sv
// top level of the target easing smoother: command decode, state arrays, easing sequencer
//
// Keeps 2*AXES current components (position x y z, then reference x y z) and
// as many targets, signed Q16.16. Each input item is one command: load one
// target, advance a number of easing ticks, jump all currents to their
// targets, or hold (targets take the current values). Every item yields one
// result carrying the six current values after the command. An advance runs
// one shared bit-serial divider over every component in turn. Each component
// passes through difference, divider start, VALUE_WIDTH+1 divide steps,
// handover of the quotient, move, and snap check. When both rates are at most
// one the advance snaps at once. The input is not ready while a command is
// being worked on. A finished result sits in the output register, and the
// next item may be taken while it waits. Configuration is to be written by
// the user through cfg_we/cfg_index/cfg_data only while the block is idle;
// the block itself does not enforce this.
module target_easing_smoother_top import tes_pkg::*; #(
	parameter int AXES        = AXES_DEF,
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_TICKS   = MAX_TICKS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// command items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// cmd[1:0], target_index[4:2], target_value[36:5], tick_count[44:37], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// pos_x[31:0], pos_y[63:32], pos_z[95:64], ref_x[127:96], ref_y[159:128],
	// ref_z[191:160]
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int COMPS = 2 * AXES;
	localparam int CW    = $clog2(COMPS);
	localparam int QW    = VALUE_WIDTH + 1;
	localparam int DW    = ((QW > FIELD_W) ? QW : FIELD_W) + 1;

	// configuration registers
	logic [RATE_W-1:0] pos_rate_q;
	logic [RATE_W-1:0] ref_rate_q;
	logic [THR_W-1:0]  thr_q;
	logic              frozen_q;

	// component state
	logic signed [VALUE_WIDTH-1:0] cur_q [COMPS];
	logic signed [VALUE_WIDTH-1:0] tgt_q [COMPS];

	// sequencer
	state_t          state_q, state_d;
	logic [CW-1:0]   comp_q;
	logic [TICK_W-1:0] ticks_q;
	logic signed [QW-1:0] diff_q;

	// output register
	logic                   m_valid_q;
	logic [OUT_TDATA_W-1:0] m_data_q;
	logic [OUT_TDATA_W-1:0] m_data_d;

	// input unpack
	cmd_t                        in_cmd;
	logic [INDEX_W-1:0]          in_index;
	logic signed [FIELD_W-1:0]   in_value;
	logic [TICK_W-1:0]           in_ticks;
	logic [TICK_W-1:0]           eff_ticks;

	logic s_accept;
	logic out_free;
	logic both_unity;
	logic last_comp;
	logic div_start;
	logic div_done;
	logic [QW-1:0]     div_mag;
	logic [QW-1:0]     div_quo;
	logic [RATE_W-1:0] div_dvs;

	logic signed [VALUE_WIDTH-1:0] cur_sel;
	logic signed [VALUE_WIDTH-1:0] tgt_sel;
	logic signed [QW-1:0]          moved;
	logic signed [DW-1:0]          span;
	logic signed [DW-1:0]          thr_s;
	logic                          snap;

	assign in_cmd   = cmd_t'(s_tdata[1:0]);
	assign in_index = s_tdata[4:2];
	assign in_value = s_tdata[36:5];
	assign in_ticks = s_tdata[44:37];

	// clamp the tick count to the configured ceiling
	assign eff_ticks = (32'(in_ticks) > MAX_TICKS) ? TICK_W'(MAX_TICKS) : in_ticks;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	// both rates at or below one: an advance that is not frozen and has ticks lands on the targets
	assign both_unity = (pos_rate_q <= UNITY_RATE) && (ref_rate_q <= UNITY_RATE);
	assign last_comp  = (comp_q == CW'(COMPS - 1));

	assign cur_sel = cur_q[comp_q];
	assign tgt_sel = tgt_q[comp_q];

	// divider operands: magnitude of the difference, rate of this component's group
	assign div_mag = diff_q[QW-1] ? QW'(-diff_q) : QW'(diff_q);
	assign div_dvs = (32'(comp_q) < AXES) ? eff_rate(pos_rate_q) : eff_rate(ref_rate_q);

	// step toward the target by the truncated quotient
	assign moved = diff_q[QW-1] ? (QW'(cur_sel) - $signed(div_quo))
	                            : (QW'(cur_sel) + $signed(div_quo));

	// snap when strictly within the threshold on either side
	assign span  = DW'(tgt_sel) - DW'(cur_sel);
	assign thr_s = $signed(DW'(thr_q));
	assign snap  = (span < thr_s) && (span > -thr_s);

	tes_div #(
		.QW(QW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.mag     (div_mag),
		.divisor (div_dvs),
		.done    (div_done),
		.quo     (div_quo)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_rate_q <= RATE_RESET;
			ref_rate_q <= RATE_RESET;
			thr_q      <= SNAP_THR_RESET;
			frozen_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_POSITION_RATE:  pos_rate_q <= cfg_data[RATE_W-1:0];
				REG_REFERENCE_RATE: ref_rate_q <= cfg_data[RATE_W-1:0];
				REG_SNAP_THRESHOLD: thr_q      <= cfg_data[THR_W-1:0];
				REG_FROZEN:         frozen_q   <= cfg_data[0];
			endcase
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and divider start
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					if (in_cmd == CMD_ADVANCE && !frozen_q && eff_ticks != '0 && !both_unity)
						state_d = ST_DIFF;
					else
						state_d = ST_FINISH;
				end
			end
			ST_DIFF: state_d = ST_DIV;
			ST_DIV: begin
				div_start = 1'b1;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done)
					state_d = ST_MOVE;
			end
			ST_MOVE: state_d = ST_SNAP;
			ST_SNAP: begin
				if (last_comp && ticks_q == TICK_W'(1))
					state_d = ST_FINISH;
				else
					state_d = ST_DIFF;
			end
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q  <= '0;
			ticks_q <= '0;
		end else begin
			if (s_accept) begin
				comp_q  <= '0;
				ticks_q <= eff_ticks;
			end else if (state_q == ST_SNAP) begin
				if (last_comp) begin
					comp_q  <= '0;
					ticks_q <= ticks_q - 1'b1;
				end else begin
					comp_q <= comp_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIFF)
			diff_q <= QW'(tgt_sel) - QW'(cur_sel);
	end

	// current and target arrays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMPS; i++) begin
				cur_q[i] <= '0;
				tgt_q[i] <= '0;
			end
		end else begin
			if (s_accept) begin
				unique case (in_cmd)
					CMD_LOAD: begin
						// out-of-range index leaves targets alone
						if (32'(in_index) < COMPS)
							tgt_q[in_index[CW-1:0]] <= VALUE_WIDTH'(in_value);
					end
					CMD_ADVANCE: begin
						if (!frozen_q && eff_ticks != '0 && both_unity) begin
							for (int i = 0; i < COMPS; i++)
								cur_q[i] <= tgt_q[i];
						end
					end
					CMD_JUMP: begin
						if (!frozen_q) begin
							for (int i = 0; i < COMPS; i++)
								cur_q[i] <= tgt_q[i];
						end
					end
					CMD_HOLD: begin
						for (int i = 0; i < COMPS; i++)
							tgt_q[i] <= cur_q[i];
					end
				endcase
			end else if (state_q == ST_MOVE) begin
				cur_q[comp_q] <= VALUE_WIDTH'(moved);
			end else if (state_q == ST_SNAP) begin
				if (snap)
					cur_q[comp_q] <= tgt_sel;
			end
		end
	end

	// result fields; a field with no component (fewer axes) is zero
	for (genvar j = 0; j < OUT_FIELDS; j++) begin : g_out
		localparam int AX = j % 3;
		if (AX < AXES) begin : g_live
			assign m_data_d[j*FIELD_W +: FIELD_W] = FIELD_W'(cur_q[(j < 3) ? AX : AXES + AX]);
		end else begin : g_none
			assign m_data_d[j*FIELD_W +: FIELD_W] = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free)
			m_data_q <= m_data_d;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_WAIT)
		else $error("divider result arrived outside the wait state");

	a_frozen_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && in_cmd == CMD_ADVANCE && frozen_q) |=> state_q == ST_FINISH)
		else $error("advance ran while frozen");

	a_ticks_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIFF) |-> (ticks_q != '0 && comp_q <= CW'(COMPS - 1)))
		else $error("easing step with no tick left or component out of range");

	a_finish_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && !out_free) |=> state_q == ST_FINISH && m_tvalid)
		else $error("result dropped while output busy");

endmodule
